// ===== rtl/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

	// Width of the signed input integer.
	localparam int VALUE_BITS = 32;

	// Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
	localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

	// Counter widths.
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W = $clog2(DIGITS + 1);

	// Character codes, trimmed to the six bits of the output field.
	localparam logic [5:0] CODE_MINUS = 6'd45;
	localparam logic [5:0] CODE_ZERO  = 6'd48;

	// Shift-and-add-3 correction for one BCD digit.
	localparam logic [3:0] DABBLE_LIMIT = 4'd5;
	localparam logic [3:0] DABBLE_ADD   = 4'd3;

	typedef logic [3:0] digit_t;

	// Commands broadcast to every digit cell.
	typedef struct packed {
		logic clear;   // start a new conversion
		logic dabble;  // correct and shift one binary bit in
		logic move;    // shift every digit one cell toward the top
	} cell_ctrl_t;

endpackage

// ===== rtl/sitda_if.sv =====
// Handshake interfaces for the integer input channel and the character output channel.
interface sitda_num_if;
	import sitda_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [VALUE_BITS-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sitda_text_if;
	import sitda_pkg::*;

	logic        valid;
	logic        ready;
	logic [5:0]  char_code;
	logic        last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/sitda_cell.sv =====
// One BCD digit cell of the double-dabble chain, which also shifts digits out.
module sitda_cell (
	input  logic                   clk,
	input  sitda_pkg::cell_ctrl_t  ctrl,
	input  logic                   carry_in,
	input  sitda_pkg::digit_t      digit_in,
	output logic                   carry_out,
	output sitda_pkg::digit_t      digit
);
	import sitda_pkg::*;

	digit_t digit_q;
	digit_t adj;

	// Add 3 when the digit would overflow past 9 after doubling.
	always_comb begin
		adj = (digit_q >= DABBLE_LIMIT) ? digit_q + DABBLE_ADD : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	// Digit register: cleared per item, fed bits during conversion, digits while printing.
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], carry_in};
		end else if (ctrl.move) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer in, decimal ASCII characters out, through a chain of BCD cells.
//
//  channel | direction | fields                 | item
//  --------+-----------+------------------------+------------------------------------
//  num     | in        | value[VALUE_BITS-1:0]  | one signed integer to print
//  text    | out       | char_code[5:0], last   | one character, last_char on final
//
// An item goes through shift-and-add-3 in the digit cells (one binary bit a cycle),
// then has its leading zero digits stripped, then sends its characters at one per
// cycle while the output is ready (minus sign included). A new item is taken only
// once the last character has left. Output stalls simply hold the current character.
// Reset clears the control state only; the digit cells are cleared when an item starts.
module signed_int_to_decimal_ascii (
	input  logic               clk,
	input  logic               arst_n,
	sitda_num_if.sink          num,
	sitda_text_if.source       text
);
	import sitda_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CONV  = 5'b00010,
		ST_STRIP = 5'b00100,
		ST_SIGN  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic                    neg_q;
	logic [BIT_CNT_W-1:0]    bit_cnt_q;
	logic [DIG_CNT_W-1:0]    dig_cnt_q;

	logic                    accept;
	logic                    strip_move;
	logic                    emit_take;
	logic [VALUE_BITS-1:0]   raw;
	cell_ctrl_t              ctrl;
	digit_t                  digits [DIGITS];
	logic                    carries [DIGITS];
	digit_t                  top_digit;

	assign raw       = num.value;
	assign accept    = num.valid && num.ready;
	assign top_digit = digits[DIGITS-1];

	// Leading zeros are dropped while more than one digit is left.
	assign strip_move = (state_q == ST_STRIP) && (top_digit == '0)
		&& (dig_cnt_q != DIG_CNT_W'(1));
	assign emit_take  = (state_q == ST_EMIT) && text.ready;

	// Commands to the digit chain.
	always_comb begin
		ctrl.clear  = accept;
		ctrl.dabble = (state_q == ST_CONV);
		ctrl.move   = strip_move || emit_take;
	end

	// Chain of digit cells, least significant digit at index zero.
	for (genvar i = 0; i < DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			sitda_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.carry_in  (mag_q[VALUE_BITS-1]),
				.digit_in  ('0),
				.carry_out (carries[i]),
				.digit     (digits[i])
			);
		end else begin : g_next
			sitda_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.carry_in  (carries[i-1]),
				.digit_in  (digits[i-1]),
				.carry_out (carries[i]),
				.digit     (digits[i])
			);
		end
	end

	// Handshake and character selection.
	assign num.ready  = (state_q == ST_IDLE);
	assign text.valid = (state_q == ST_SIGN) || (state_q == ST_EMIT);

	always_comb begin
		if (state_q == ST_SIGN) begin
			text.char_code = CODE_MINUS;
			text.last_char = 1'b0;
		end else begin
			text.char_code = CODE_ZERO + {2'b00, top_digit};
			text.last_char = (dig_cnt_q == DIG_CNT_W'(1));
		end
	end

	// Magnitude shifter: loaded on accept, fed MSB first into the chain.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[VALUE_BITS-1];
			mag_q <= raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// Sequencer for conversion, zero stripping and character output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_cnt_q <= BIT_CNT_W'(VALUE_BITS - 1);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					if (bit_cnt_q == '0) begin
						dig_cnt_q <= DIG_CNT_W'(DIGITS);
						state_q   <= ST_STRIP;
					end
				end
				ST_STRIP: begin
					if (strip_move) begin
						dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (text.ready) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_take) begin
						dig_cnt_q <= dig_cnt_q - DIG_CNT_W'(1);
						if (dig_cnt_q == DIG_CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/decimal_text_checker.sv =====
// Checker that predicts the decimal text of every accepted integer and compares each character.
`timescale 1ns / 1ps
module decimal_text_checker (
	input  logic  clk,
	input  logic  arst_n,
	sitda_num_if  num,
	sitda_text_if text,
	input  logic  closing,
	output int    fail_count,
	output int    pending,
	output int    chars_checked
);
	import sitda_pkg::*;

	// One predicted character, tagged with the integer it belongs to.
	typedef struct packed {
		logic [VALUE_BITS-1:0] number;
		logic [5:0]            code;
		logic                  last;
	} text_char_t;

	text_char_t expected_chars[$];
	int         mismatch_tally = 0;
	int         checked_tally = 0;
	int         mismatch_count = 0;

	initial begin
		pending = 0;
		chars_checked = 0;
	end

	// Characters left over at the close of the run count as failures too.
	assign fail_count = mismatch_count + (closing ? pending : 0);

	// Work out the decimal text of one integer and queue it, most significant first.
	task automatic queue_decimal_text(input logic [VALUE_BITS-1:0] raw);
		logic                  negative;
		logic [VALUE_BITS-1:0] magnitude;
		logic [3:0]            digits [0:DIGITS-1];
		int                    ndig;
		int                    i;
		text_char_t            ch;
		negative = raw[VALUE_BITS-1];
		// Negation within the field width gives the most negative value's magnitude exactly.
		magnitude = negative ? (~raw + 1'b1) : raw;
		ndig = 0;
		do begin
			digits[ndig] = 4'(magnitude % 10);
			magnitude = magnitude / 10;
			ndig++;
		end while (magnitude != 0);
		ch.number = raw;
		if (negative) begin
			ch.code = CODE_MINUS;
			ch.last = 1'b0;
			expected_chars.push_back(ch);
		end
		for (i = ndig - 1; i >= 0; i--) begin
			ch.code = CODE_ZERO + 6'(digits[i]);
			ch.last = (i == 0);
			expected_chars.push_back(ch);
		end
	endtask

	// Predict on every accepted integer and compare every accepted character.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (num.valid && num.ready)
				queue_decimal_text(num.value);
			if (text.valid && text.ready) begin
				if (expected_chars.size() == 0) begin
					mismatch_tally++;
					if (mismatch_tally <= 10)
						$display("%0t: character %0d (last %b) arrived with nothing expected",
							$realtime, text.char_code, text.last_char);
				end else begin
					want = expected_chars.pop_front();
					checked_tally++;
					if (text.char_code !== want.code || text.last_char !== want.last) begin
						mismatch_tally++;
						if (mismatch_tally <= 10)
							$display("%0t: value %0d: expected char %0d last %b, got %0d last %b",
								$realtime, $signed(want.number), want.code, want.last,
								text.char_code, text.last_char);
					end
				end
			end
			mismatch_count <= mismatch_tally;
			chars_checked <= checked_tally;
			pending <= expected_chars.size();
		end
	end

endmodule

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
// Testbench top: clock, reset and stimulus for the decimal text converter, plus the verdict.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii_tb;
	import sitda_pkg::*;

	localparam int RANDOM_ITEMS = 300;

	logic clk;
	logic arst_n;
	logic closing;
	bit   steady;
	int   fail_count;
	int   pending;
	int   chars_checked;
	int   sent;
	int   negatives;

	sitda_num_if  num_ch ();
	sitda_text_if text_ch ();

	signed_int_to_decimal_ascii dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	decimal_text_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.num           (num_ch),
		.text          (text_ch),
		.closing       (closing),
		.fail_count    (fail_count),
		.pending       (pending),
		.chars_checked (chars_checked)
	);

	// Edge cases: zero, single digits, decade boundaries and both extremes.
	logic [VALUE_BITS-1:0] directed [0:19] = '{
		32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, -32'sd999999999,
		-32'sd214748364, 32'd214748364, 32'd123456789, -32'sd1000000, -32'sd7,
		32'd4294967, 32'd5
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random integer with a random number of significant digits and a random sign.
	function automatic logic [VALUE_BITS-1:0] random_number();
		logic [VALUE_BITS-1:0] v;
		int                    roll;
		int                    k;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			// Near a power of ten, where the digit count changes.
			v = 1;
			for (k = $urandom_range(0, 9); k > 0; k--)
				v = v * 10;
			v = v + $urandom_range(0, 2) - 1;
		end else if (roll < 20) begin
			v = $urandom_range(0, 1) ? {1'b1, {(VALUE_BITS-1){1'b0}}}
			                         : {1'b0, {(VALUE_BITS-1){1'b1}}};
			return v;
		end else begin
			v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
		end
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// Offer one integer after a random gap and hold it until it is taken.
	task automatic send_number(input logic [VALUE_BITS-1:0] v);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			num_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		num_ch.valid <= 1'b1;
		num_ch.value <= v;
		do @(posedge clk); while (!num_ch.ready);
		sent++;
		if (v[VALUE_BITS-1])
			negatives++;
	endtask

	// Stop offering integers until every predicted character has come out.
	task automatic wait_drained();
		num_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Receiver side: random stalls, none while a steady stretch runs.
	initial begin
		int stall;
		text_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = steady ? 0 : pick_gap();
			if (stall > 0) begin
				text_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			text_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Reset, directed integers, then random ones with steady stretches and drain pauses.
	initial begin
		int n;
		arst_n = 1'b0;
		closing = 1'b0;
		steady = 1'b0;
		sent = 0;
		negatives = 0;
		num_ch.valid <= 1'b0;
		num_ch.value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < 20; n++)
			send_number(directed[n]);
		wait_drained();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 75 == 40)
				steady = 1'b1;
			else if (n % 75 == 60)
				steady = 1'b0;
			if (n == RANDOM_ITEMS / 2)
				wait_drained();
			send_number(random_number());
		end
		num_ch.valid <= 1'b0;

		// Let the last characters out, then allow for any work still in flight.
		do @(posedge clk); while (pending != 0);
		repeat (60) @(posedge clk);
		closing <= 1'b1;
		@(posedge clk);

		$display("Converted %0d integers (%0d negative) including both extremes and zero;",
			sent, negatives);
		$display("checked %0d characters under random stalls on both channels.", chars_checked);
		if (fail_count == 0)
			$display("[signed_int_to_decimal_ascii] OK");
		else
			$display("[signed_int_to_decimal_ascii] ERROR");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20_000_000;
		$display("[signed_int_to_decimal_ascii] ERROR");
		$finish;
	end

endmodule
